[sv/ppq_pkg.sv]
package ppq_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int SQ_W         = 2 * COORD_W;
    localparam int DIST_W       = SQ_W + 1;

    localparam logic [DIST_W-1:0] THRESH_RESET = DIST_W'(64);

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    // products of one vertex, folded into the running answer one cell later
    typedef struct packed {
        logic                     active;
        logic                     straddle;
        logic                     dy_pos;
        logic [IDX_W-1:0]         idx;
        logic signed [PROD_W-1:0] lhs;
        logic signed [PROD_W-1:0] rhs;
        logic [DIST_W-1:0]        sq_dist;
    } t_prod;

    typedef struct packed {
        logic              in_poly;
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] sq_dist;
    } t_acc;

    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        t_prod                     prod;
        t_acc                      acc;
    } t_token;

    function automatic t_acc fold_vertex(t_acc acc, t_prod p, logic [DIST_W-1:0] thr);
        t_acc res;
        logic hit;
        res = acc;
        hit = 1'b0;
        if (p.active) begin
            if (p.straddle) begin
                hit = p.dy_pos ? ($signed(p.lhs) <= $signed(p.rhs))
                               : ($signed(p.lhs) >= $signed(p.rhs));
            end
            res.in_poly = acc.in_poly ^ hit;
            if ((p.sq_dist <= thr) && (!acc.found || (p.sq_dist < acc.sq_dist))) begin
                res.found   = 1'b1;
                res.idx     = p.idx;
                res.sq_dist = p.sq_dist;
            end
        end
        return res;
    endfunction

endpackage

[sv/ppq_cell.sv]
module ppq_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [ppq_pkg::IDX_W-1:0]          i_index,
    input  logic [ppq_pkg::CNT_W-1:0]          i_count,
    input  logic [ppq_pkg::DIST_W-1:0]         i_thr,
    input  logic                               i_wr_en,
    input  logic signed [ppq_pkg::COORD_W-1:0] i_wr_x,
    input  logic signed [ppq_pkg::COORD_W-1:0] i_wr_y,
    input  logic signed [ppq_pkg::COORD_W-1:0] i_prev_x,
    input  logic signed [ppq_pkg::COORD_W-1:0] i_prev_y,
    input  ppq_pkg::t_token                    i_token,
    output logic signed [ppq_pkg::COORD_W-1:0] o_x,
    output logic signed [ppq_pkg::COORD_W-1:0] o_y,
    output ppq_pkg::t_token                    o_token
);
    import ppq_pkg::*;

    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    t_token                    r_token;
    t_token                    n_token;

    logic signed [DIFF_W-1:0]  w_dpy;
    logic signed [DIFF_W-1:0]  w_dpx;
    logic signed [DIFF_W-1:0]  w_dxba;
    logic signed [DIFF_W-1:0]  w_dyba;
    logic signed [PROD_W-1:0]  w_sqx;
    logic signed [PROD_W-1:0]  w_sqy;

    // vertex a is this cell, vertex b the previous one in the ring
    assign w_dpy  = {i_token.py[COORD_W-1], i_token.py} - {r_y[COORD_W-1], r_y};
    assign w_dpx  = {i_token.px[COORD_W-1], i_token.px} - {r_x[COORD_W-1], r_x};
    assign w_dxba = {i_prev_x[COORD_W-1], i_prev_x} - {r_x[COORD_W-1], r_x};
    assign w_dyba = {i_prev_y[COORD_W-1], i_prev_y} - {r_y[COORD_W-1], r_y};
    assign w_sqx  = w_dpx * w_dpx;
    assign w_sqy  = w_dpy * w_dpy;

    always_comb begin
        n_token               = i_token;
        n_token.acc           = fold_vertex(i_token.acc, i_token.prod, i_thr);
        n_token.prod.active   = ({1'b0, i_index} < i_count);
        n_token.prod.straddle = (r_y > i_token.py) != (i_prev_y > i_token.py);
        n_token.prod.dy_pos   = (w_dyba > 0);
        n_token.prod.idx      = i_index;
        n_token.prod.lhs      = w_dpy * w_dxba;
        n_token.prod.rhs      = w_dpx * w_dyba;
        n_token.prod.sq_dist  = {1'b0, w_sqx[SQ_W-1:0]} + {1'b0, w_sqy[SQ_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token.valid <= 1'b0;
        end else begin
            r_token.valid <= n_token.valid;
        end
        r_token.px   <= n_token.px;
        r_token.py   <= n_token.py;
        r_token.prod <= n_token.prod;
        r_token.acc  <= n_token.acc;
    end

    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_token = r_token;

endmodule

[sv/polygon_point_query.sv]
// a query walks all 16 vertex cells, each registering its token, then the output register
// start is taken only while busy is low; clear and append do not raise busy
// busy stays high while a query walks the cell chain
// reset (synchronous, active low) empties the table and sets the threshold to 64
module polygon_point_query (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_action,
    input  logic signed [ppq_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [ppq_pkg::COORD_W-1:0]  i_coord_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ppq_pkg::DIST_W-1:0]          i_cfg_data,
    output logic                                o_strobe,
    output logic                                o_inside_res,
    output logic                                o_found,
    output logic [3:0]                          o_near_index,
    output logic [ppq_pkg::DIST_W-1:0]          o_near_sq_dist,
    output logic [4:0]                          o_vertex_count
);
    import ppq_pkg::*;

    logic                      r_busy;
    logic [CNT_W-1:0]          r_count;
    logic signed [COORD_W-1:0] r_last_x;
    logic signed [COORD_W-1:0] r_last_y;
    logic [DIST_W-1:0]         r_thr;
    logic                      r_strobe;
    t_acc                      r_res;
    logic [CNT_W-1:0]          r_res_count;

    logic                      w_accept;
    logic                      w_append;
    t_token                    w_tok [MAX_VERTICES+1];
    logic signed [COORD_W-1:0] w_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] w_y [MAX_VERTICES];
    t_acc                      w_final;

    assign w_accept = start && !r_busy;
    assign w_append = w_accept && (i_action == ACT_APPEND)
                      && (r_count < CNT_W'(MAX_VERTICES));

    // query enters the chain with an empty answer
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = w_accept && (i_action == ACT_QUERY);
        w_tok[0].px    = i_coord_x;
        w_tok[0].py    = i_coord_y;
    end

    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        ppq_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (IDX_W'(g)),
            .i_count  (r_count),
            .i_thr    (r_thr),
            .i_wr_en  (w_append && (r_count[IDX_W-1:0] == IDX_W'(g))),
            .i_wr_x   (i_coord_x),
            .i_wr_y   (i_coord_y),
            .i_prev_x ((g == 0) ? r_last_x : w_x[(g == 0) ? 0 : g-1]),
            .i_prev_y ((g == 0) ? r_last_y : w_y[(g == 0) ? 0 : g-1]),
            .i_token  (w_tok[g]),
            .o_x      (w_x[g]),
            .o_y      (w_y[g]),
            .o_token  (w_tok[g+1])
        );
    end

    assign w_final = fold_vertex(w_tok[MAX_VERTICES].acc, w_tok[MAX_VERTICES].prod, r_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_count  <= '0;
            r_thr    <= THRESH_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_tok[MAX_VERTICES].valid;
            if (w_tok[0].valid) begin
                r_busy <= 1'b1;
            end else if (w_tok[MAX_VERTICES].valid) begin
                r_busy <= 1'b0;
            end
            if (w_accept && (i_action == ACT_CLEAR)) begin
                r_count <= '0;
            end else if (w_append) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_append) begin
            r_last_x <= i_coord_x;
            r_last_y <= i_coord_y;
        end
        if (w_tok[MAX_VERTICES].valid) begin
            r_res       <= w_final;
            r_res_count <= r_count;
        end
    end

    assign busy           = r_busy;
    assign o_cfg_ready    = !r_busy;
    assign o_strobe       = r_strobe;
    assign o_inside_res   = r_res.in_poly;
    assign o_found        = r_res.found;
    assign o_near_index   = 4'(r_res.idx);
    assign o_near_sq_dist = r_res.sq_dist;
    assign o_vertex_count = 5'(r_res_count);

endmodule

[tb/sv/ppq_checker.sv]
`timescale 1ns / 100ps

module ppq_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [1:0]                          i_action,
    input  logic signed [ppq_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [ppq_pkg::COORD_W-1:0]  i_coord_y,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [ppq_pkg::DIST_W-1:0]          i_cfg_data,
    input  logic                                i_strobe,
    input  logic                                i_inside_res,
    input  logic                                i_found,
    input  logic [3:0]                          i_near_index,
    input  logic [ppq_pkg::DIST_W-1:0]          i_near_sq_dist,
    input  logic [4:0]                          i_vertex_count,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import ppq_pkg::*;

    typedef struct packed {
        logic              in_poly;
        logic              found;
        logic [3:0]        idx;
        logic [DIST_W-1:0] sq_dist;
        logic [4:0]        count;
    } t_query_answer;

    logic signed [COORD_W-1:0] vert_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] vert_y [MAX_VERTICES];
    int                        held;
    logic [DIST_W-1:0]         near_thr;
    t_query_answer             answers_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        held         = 0;
        near_thr     = THRESH_RESET;
    end

    function automatic t_query_answer answer_query(longint px, longint py);
        t_query_answer a;
        longint        xa, ya, xb, yb, dy, lhs, rhs, ex, ey, sq, best;
        int            i, prev;
        a    = '0;
        best = 0;
        prev = (held > 0) ? held - 1 : 0;
        for (i = 0; i < held; i++) begin
            xa = vert_x[i];
            ya = vert_y[i];
            xb = vert_x[prev];
            yb = vert_y[prev];
            // edge counts when py is in its half-open y span and the crossing is not right of px
            if ((ya > py) != (yb > py)) begin
                dy  = yb - ya;
                lhs = (py - ya) * (xb - xa);
                rhs = (px - xa) * dy;
                if ((dy > 0) ? (lhs <= rhs) : (lhs >= rhs))
                    a.in_poly = !a.in_poly;
            end
            ex = xa - px;
            ey = ya - py;
            sq = ex * ex + ey * ey;
            if (sq <= longint'(near_thr) && (!a.found || sq < best)) begin
                a.found   = 1'b1;
                a.idx     = i[3:0];
                a.sq_dist = sq[DIST_W-1:0];
                best      = sq;
            end
            prev = i;
        end
        a.count = held[4:0];
        return a;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_result();
        t_query_answer want;
        if (answers_due.size() == 0) begin
            report_mismatch("result with no query outstanding", 0, 0);
            return;
        end
        want = answers_due.pop_front();
        if (i_inside_res !== want.in_poly)
            report_mismatch("inside_res", i_inside_res, want.in_poly);
        if (i_found !== want.found)
            report_mismatch("found", i_found, want.found);
        if (i_near_index !== want.idx)
            report_mismatch("near index", i_near_index, want.idx);
        if (i_near_sq_dist !== want.sq_dist)
            report_mismatch("near squared distance", i_near_sq_dist, want.sq_dist);
        if (i_vertex_count !== want.count)
            report_mismatch("vertex_count", i_vertex_count, want.count);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held     = 0;
            near_thr = THRESH_RESET;
            answers_due.delete();
        end else begin
            if (i_strobe)
                check_result();
            if (i_start && !i_busy) begin
                case (i_action)
                    ACT_CLEAR: begin
                        held = 0;
                    end
                    ACT_APPEND: begin
                        if (held < MAX_VERTICES) begin
                            vert_x[held] = i_coord_x;
                            vert_y[held] = i_coord_y;
                            held++;
                        end
                    end
                    ACT_QUERY: begin
                        answers_due = {answers_due, answer_query(i_coord_x, i_coord_y)};
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cfg_valid && i_cfg_ready)
                near_thr = i_cfg_data;
        end
        o_pending = answers_due.size();
    end

endmodule

[tb/sv/tb_polygon_point_query.sv]
`timescale 1ns / 100ps

module tb_polygon_point_query;
    import ppq_pkg::*;

    localparam logic [1:0]        ACT_UNUSED   = 2'd3;
    localparam logic [DIST_W-1:0] DIST_MAX     = 33'd8589672450;
    localparam int                LATENCY      = 17;
    localparam int                CYCLE_LIMIT  = 1000000;
    localparam int                ITEM_TARGET  = 1650;
    localparam int                N_PHASES     = 8;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                i_action;
    logic signed [COORD_W-1:0] i_coord_x;
    logic signed [COORD_W-1:0] i_coord_y;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [DIST_W-1:0]         i_cfg_data;
    logic                      o_strobe;
    logic                      o_inside_res;
    logic                      o_found;
    logic [3:0]                o_near_index;
    logic [DIST_W-1:0]         o_near_sq_dist;
    logic [4:0]                o_vertex_count;

    int n_fail;
    int n_pending;
    int items_sent;
    int cycles;
    bit no_gaps;

    polygon_point_query dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_inside_res   (o_inside_res),
        .o_found        (o_found),
        .o_near_index   (o_near_index),
        .o_near_sq_dist (o_near_sq_dist),
        .o_vertex_count (o_vertex_count)
    );

    ppq_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_strobe       (o_strobe),
        .i_inside_res   (o_inside_res),
        .i_found        (o_found),
        .i_near_index   (o_near_index),
        .i_near_sq_dist (o_near_sq_dist),
        .i_vertex_count (o_vertex_count),
        .o_fail_count   (n_fail),
        .o_pending      (n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("polygon_point_query regression: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(int spread);
        if (spread == 0)
            return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic logic signed [COORD_W-1:0] nudge(logic signed [COORD_W-1:0] base);
        int v;
        v = int'(base) + int'($urandom_range(0, 6)) - 3;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return COORD_W'(v);
    endfunction

    function automatic logic [DIST_W-1:0] pick_threshold();
        logic [DIST_W-1:0] v;
        case ($urandom_range(0, 2))
            0: v = DIST_W'($urandom_range(0, 200));
            1: v = DIST_W'($urandom_range(0, 5000000));
            default: v = {1'($urandom), 32'($urandom)};
        endcase
        return (v > DIST_MAX) ? DIST_MAX : v;
    endfunction

    // start stays high from one transaction to the next when there is no gap
    task automatic send_item(logic [1:0] act, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_action  <= act;
        i_coord_x <= x;
        i_coord_y <= y;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(negedge i_clk); while (n_pending != 0 || busy);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [DIST_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_polygon(int spread);
        logic signed [COORD_W-1:0] xs [$];
        logic signed [COORD_W-1:0] ys [$];
        int n, k, r, v;
        r = $urandom_range(0, 9);
        if (r < 1)
            n = $urandom_range(0, 2);
        else if (r < 8)
            n = $urandom_range(3, 16);
        else
            n = $urandom_range(16, 20);
        send_item(ACT_CLEAR, pick_coord(0), pick_coord(0));
        repeat (n) begin
            xs = {xs, pick_coord(spread)};
            ys = {ys, pick_coord(spread)};
            send_item(ACT_APPEND, xs[$], ys[$]);
        end
        k = $urandom_range(1, 6);
        repeat (k) begin
            r = $urandom_range(0, 9);
            if (n > 0 && r < 5) begin
                v = $urandom_range(0, n - 1);
                if (r == 0)
                    send_item(ACT_QUERY, xs[v], ys[v]);
                else
                    send_item(ACT_QUERY, nudge(xs[v]), nudge(ys[v]));
            end else begin
                send_item(ACT_QUERY, pick_coord(spread), pick_coord(spread));
            end
        end
    endtask

    initial begin
        int phase, r, spread;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_action    <= ACT_CLEAR;
        i_coord_x   <= '0;
        i_coord_y   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        items_sent  = 0;
        no_gaps     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, then a square on the coordinate extremes
        send_item(ACT_QUERY, 16'sd0, 16'sd0);
        send_item(ACT_APPEND, -16'sd32768, -16'sd32768);
        send_item(ACT_QUERY, -16'sd32768, -16'sd32768);
        send_item(ACT_APPEND, 16'sd32767, -16'sd32768);
        send_item(ACT_QUERY, 16'sd0, -16'sd32768);
        send_item(ACT_APPEND, 16'sd32767, 16'sd32767);
        send_item(ACT_APPEND, -16'sd32768, 16'sd32767);
        send_item(ACT_QUERY, 16'sd0, 16'sd0);
        send_item(ACT_QUERY, 16'sd32767, 16'sd32767);
        send_item(ACT_QUERY, -16'sd32768, 16'sd0);
        send_item(ACT_QUERY, 16'sd32767, 16'sd0);
        send_item(ACT_UNUSED, -16'sd1, -16'sd1);
        send_item(ACT_QUERY, -16'sd32767, -16'sd32767);
        send_item(ACT_CLEAR, 16'sd0, 16'sd0);
        send_item(ACT_QUERY, 16'sd5, 16'sd5);
        // triangle with a horizontal edge
        send_item(ACT_APPEND, 16'sd0, 16'sd0);
        send_item(ACT_APPEND, 16'sd10, 16'sd0);
        send_item(ACT_APPEND, 16'sd0, 16'sd10);
        send_item(ACT_QUERY, 16'sd2, 16'sd2);
        send_item(ACT_QUERY, 16'sd0, 16'sd5);
        send_item(ACT_QUERY, 16'sd10, 16'sd10);

        // largest distance at a threshold equal to that distance, tie between equal vertices
        write_threshold(DIST_MAX);
        send_item(ACT_CLEAR, -16'sd1, 16'sd0);
        send_item(ACT_APPEND, -16'sd32768, -16'sd32768);
        send_item(ACT_APPEND, -16'sd32768, -16'sd32768);
        send_item(ACT_QUERY, 16'sd32767, 16'sd32767);

        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: write_threshold('0);
                1: write_threshold(DIST_W'(64));
                2: write_threshold(DIST_MAX);
                3: write_threshold(33'h0_FFFF_FFFF);
                default: write_threshold(pick_threshold());
            endcase
            no_gaps = (phase % 3 == 1);
            while (items_sent < (ITEM_TARGET * (phase + 1)) / N_PHASES) begin
                r = $urandom_range(0, 99);
                if (r < 85) begin
                    r = $urandom_range(0, 9);
                    spread = (r < 4) ? 20 : (r < 7) ? 2000 : 0;
                    run_polygon(spread);
                end else if (r < 98) begin
                    send_item(2'($urandom_range(0, 3)), pick_coord(0), pick_coord(0));
                end else begin
                    wait_idle();
                end
            end
        end

        wait_idle();
        if (n_fail == 0)
            $display("polygon_point_query regression: pass");
        else
            $display("polygon_point_query regression: fail");
        $finish;
    end

endmodule
